// ----- rtl/oqm_pkg.sv -----
`timescale 1ns / 1ps

package oqm_pkg;

	localparam int SLOTS_DEFAULT = 8;

	localparam int KEY_W    = 12;
	localparam int HEIGHT_W = 8;
	localparam int OCC_W    = 3;
	localparam int QUOT_W   = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DONE
	} state_t;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

endpackage

// ----- rtl/overwriting_queue_with_mean_unit.sv -----
`timescale 1ns / 1ps

// Ring queue of SLOTS slots that holds up to SLOTS-1 entries of key and height,
// keys and heights kept in two single-port synchronous memories. An insert
// transaction drops the oldest entry when the queue is full, appends the new
// one and returns the mean stored height rounded half up; a remove transaction
// pops the oldest entry, or flags underflow and changes nothing when the queue
// is empty. Items are handled one at a time: a remove passes through the
// execute and done states, and an insert through execute, the bit-per-cycle
// restoring divider that forms the mean from the running height sum, and done.
// A new transaction is accepted while the previous result still waits in the
// output register.
module overwriting_queue_with_mean_unit
	import oqm_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                item_valid,
	output logic                item_stall,
	input  logic                kind,
	input  logic [KEY_W-1:0]    record_key,
	input  logic [HEIGHT_W-1:0] height,

	output logic                result_valid,
	input  logic                result_stall,
	output logic [QUOT_W-1:0]   mean_height,
	output logic [KEY_W-1:0]    removed_key,
	output logic [HEIGHT_W-1:0] removed_height,
	output logic [OCC_W-1:0]    occupancy,
	output logic                dropped_oldest,
	output logic                underflow
);

	localparam int CW = $clog2(SLOTS);
	localparam int SW = HEIGHT_W + CW;
	localparam int NW = SW + 1;
	localparam int STEP_W = $clog2(QUOT_W);
	localparam logic [CW-1:0] LAST_SLOT = CW'(SLOTS - 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

	logic [KEY_W-1:0]    key_mem    [SLOTS];
	logic [HEIGHT_W-1:0] height_mem [SLOTS];

	state_t state_q, state_d;

	logic [CW-1:0] head_q, tail_q, cnt_q;
	logic [SW-1:0] sum_q;

	logic                kind_q;
	logic [KEY_W-1:0]    key_q;
	logic [HEIGHT_W-1:0] height_q;

	logic [KEY_W-1:0]    rd_key_q;
	logic [HEIGHT_W-1:0] rd_height_q;

	logic [NW-1:0]       rem_q;
	logic [NW-1:0]       dsh_q;
	logic [QUOT_W-1:0]   quot_q;
	logic [STEP_W-1:0]   step_q;

	logic [KEY_W-1:0]    rkey_q;
	logic [HEIGHT_W-1:0] rhgt_q;
	logic                drop_q;
	logic                under_q;

	logic item_take;
	logic out_free;
	logic full, empty;
	logic [CW-1:0] head_next, tail_next, cnt_ins;
	logic [SW-1:0] sum_ins, sum_rem;
	logic rem_ge;

	assign item_take  = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign out_free   = !result_valid || !result_stall;

	assign full      = (cnt_q == LAST_SLOT);
	assign empty     = (cnt_q == '0);
	assign head_next = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
	assign cnt_ins   = full ? cnt_q : cnt_q + 1'b1;
	assign sum_rem   = sum_q - SW'(rd_height_q);
	assign sum_ins   = (full ? sum_rem : sum_q) + SW'(height_q);
	assign rem_ge    = (rem_q >= dsh_q);

	// memories: read the head slot on acceptance, write the tail slot on insert
	always_ff @(posedge clk) begin
		if (item_take) begin
			rd_key_q    <= key_mem[head_q];
			rd_height_q <= height_mem[head_q];
		end
		if (state_q == ST_EXEC && kind_q == KIND_INSERT) begin
			key_mem[tail_q]    <= key_q;
			height_mem[tail_q] <= height_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_take) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = (kind_q == KIND_INSERT) ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				if (step_q == LAST_STEP) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// queue pointers, count and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			sum_q  <= '0;
		end else if (state_q == ST_EXEC) begin
			if (kind_q == KIND_INSERT) begin
				tail_q <= tail_next;
				cnt_q  <= cnt_ins;
				sum_q  <= sum_ins;
				if (full) head_q <= head_next;
			end else if (!empty) begin
				head_q <= head_next;
				cnt_q  <= cnt_q - 1'b1;
				sum_q  <= sum_rem;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			kind_q   <= kind;
			key_q    <= record_key;
			height_q <= height;
		end
	end

	// item execution and restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			step_q <= '0;
			quot_q <= '0;
			if (kind_q == KIND_INSERT) begin
				rkey_q  <= '0;
				rhgt_q  <= '0;
				drop_q  <= full;
				under_q <= 1'b0;
				// mean rounded half up: (2*sum + n) / (2*n)
				rem_q   <= {sum_ins, 1'b0} + NW'(cnt_ins);
				dsh_q   <= NW'({cnt_ins, 1'b0}) << (QUOT_W - 1);
			end else begin
				drop_q  <= 1'b0;
				under_q <= empty;
				rkey_q  <= empty ? '0 : rd_key_q;
				rhgt_q  <= empty ? '0 : rd_height_q;
			end
		end else if (state_q == ST_DIV) begin
			if (rem_ge) rem_q <= rem_q - dsh_q;
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QUOT_W-2:0], rem_ge};
			step_q <= step_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			mean_height    <= quot_q;
			removed_key    <= rkey_q;
			removed_height <= rhgt_q;
			occupancy      <= OCC_W'(cnt_q);
			dropped_oldest <= drop_q;
			underflow      <= under_q;
		end
	end

endmodule

// ----- bench/tb_overwriting_queue_with_mean_unit.sv -----
`timescale 1ns / 1ps

module tb_overwriting_queue_with_mean_unit;
	import oqm_pkg::*;

	localparam int SLOTS       = SLOTS_DEFAULT;
	localparam int IDX_W       = $clog2(SLOTS);
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_OPS  = 1200;
	localparam int IDLE_PCT    = 23;

	typedef struct packed {
		logic [QUOT_W-1:0]   mean_height;
		logic [KEY_W-1:0]    removed_key;
		logic [HEIGHT_W-1:0] removed_height;
		logic [OCC_W-1:0]    occupancy;
		logic                dropped_oldest;
		logic                underflow;
	} queue_result_t;

	typedef struct packed {
		logic                op_kind;
		logic [KEY_W-1:0]    op_key;
		logic [HEIGHT_W-1:0] op_height;
		logic                pinned;
		queue_result_t       pinned_result;
	} queue_row_t;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                item_valid     = 1'b0;
	logic                item_stall;
	logic                kind           = KIND_INSERT;
	logic [KEY_W-1:0]    record_key     = '0;
	logic [HEIGHT_W-1:0] height         = '0;
	logic                result_valid;
	logic                result_stall   = 1'b0;
	logic [QUOT_W-1:0]   mean_height;
	logic [KEY_W-1:0]    removed_key;
	logic [HEIGHT_W-1:0] removed_height;
	logic [OCC_W-1:0]    occupancy;
	logic                dropped_oldest;
	logic                underflow;

	overwriting_queue_with_mean_unit #(
		.SLOTS(SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind(kind),
		.record_key(record_key),
		.height(height),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.mean_height(mean_height),
		.removed_key(removed_key),
		.removed_height(removed_height),
		.occupancy(occupancy),
		.dropped_oldest(dropped_oldest),
		.underflow(underflow)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// mirror of the ring queue
	logic [KEY_W-1:0]    mirror_keys    [SLOTS];
	logic [HEIGHT_W-1:0] mirror_heights [SLOTS];
	int                  oldest_slot = 0;
	int                  free_slot   = 0;
	int unsigned         stored_sum  = 0;

	queue_result_t outcomes_due [$];
	queue_row_t    directed_rows [$];
	int            mismatch_count = 0;
	logic          steady         = 1'b0;
	logic          pressure_go    = 1'b0;

	function automatic int stored_count();
		return (free_slot + SLOTS - oldest_slot) % SLOTS;
	endfunction

	function automatic queue_result_t queue_op_outcome(logic op_kind,
			logic [KEY_W-1:0] op_key, logic [HEIGHT_W-1:0] op_height);
		queue_result_t r;
		int unsigned   cnt;
		int unsigned   mean_val;
		r = '0;
		if (op_kind == KIND_INSERT) begin
			// full queue: the oldest entry makes room first
			if ((free_slot + 1) % SLOTS == oldest_slot) begin
				stored_sum -= mirror_heights[oldest_slot[IDX_W-1:0]];
				oldest_slot = (oldest_slot + 1) % SLOTS;
				r.dropped_oldest = 1'b1;
			end
			mirror_keys[free_slot[IDX_W-1:0]]    = op_key;
			mirror_heights[free_slot[IDX_W-1:0]] = op_height;
			stored_sum += op_height;
			free_slot = (free_slot + 1) % SLOTS;
			cnt = stored_count();
			// rounded half up without fractions
			mean_val = (2 * stored_sum + cnt) / (2 * cnt);
			r.mean_height = mean_val[QUOT_W-1:0];
		end else if (oldest_slot == free_slot) begin
			r.underflow = 1'b1;
		end else begin
			r.removed_key    = mirror_keys[oldest_slot[IDX_W-1:0]];
			r.removed_height = mirror_heights[oldest_slot[IDX_W-1:0]];
			stored_sum -= mirror_heights[oldest_slot[IDX_W-1:0]];
			oldest_slot = (oldest_slot + 1) % SLOTS;
		end
		r.occupancy = OCC_W'(stored_count());
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < 50)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic add_row(input logic op_kind, input int op_key, input int op_height,
			input int pinned, input int mean, input int rkey, input int rhgt,
			input int occ, input int drp, input int und);
		queue_row_t row;
		row.op_kind                      = op_kind;
		row.op_key                       = op_key[KEY_W-1:0];
		row.op_height                    = op_height[HEIGHT_W-1:0];
		row.pinned                       = pinned[0];
		row.pinned_result.mean_height    = mean[QUOT_W-1:0];
		row.pinned_result.removed_key    = rkey[KEY_W-1:0];
		row.pinned_result.removed_height = rhgt[HEIGHT_W-1:0];
		row.pinned_result.occupancy      = occ[OCC_W-1:0];
		row.pinned_result.dropped_oldest = drp[0];
		row.pinned_result.underflow      = und[0];
		directed_rows.push_back(row);
	endtask

	task automatic send_item(input queue_row_t row);
		queue_result_t predicted;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		kind       <= row.op_kind;
		record_key <= row.op_key;
		height     <= row.op_height;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predicted = queue_op_outcome(row.op_kind, row.op_key, row.op_height);
		outcomes_due.push_back(row.pinned ? row.pinned_result : predicted);
	endtask

	initial begin : sender
		queue_row_t row;
		int         remove_pct;
		int         height_pick;
		int         n;
		// empty queue, extremes and rounding
		add_row(KIND_REMOVE, 0,      0,   1, 0,   0,    0,   0, 0, 1);
		add_row(KIND_INSERT, 0,      0,   1, 0,   0,    0,   1, 0, 0);
		add_row(KIND_INSERT, 4095,   255, 1, 128, 0,    0,   2, 0, 0);
		add_row(KIND_REMOVE, 0,      0,   1, 0,   0,    0,   1, 0, 0);
		add_row(KIND_REMOVE, 0,      0,   1, 0,   4095, 255, 0, 0, 0);
		add_row(KIND_REMOVE, 0,      0,   1, 0,   0,    0,   0, 0, 1);
		add_row(KIND_INSERT, 1,      1,   1, 1,   0,    0,   1, 0, 0);
		add_row(KIND_INSERT, 2,      2,   1, 2,   0,    0,   2, 0, 0);
		// fill up, then overwrite the oldest twice
		add_row(KIND_INSERT, 'h800,  255, 0, 0,   0,    0,   0, 0, 0);
		add_row(KIND_INSERT, 'h400,  255, 0, 0,   0,    0,   0, 0, 0);
		add_row(KIND_INSERT, 'h0ff,  255, 0, 0,   0,    0,   0, 0, 0);
		add_row(KIND_INSERT, 'hf00,  255, 0, 0,   0,    0,   0, 0, 0);
		add_row(KIND_INSERT, 'h123,  255, 0, 0,   0,    0,   0, 0, 0);
		add_row(KIND_INSERT, 'haaa,  255, 0, 0,   0,    0,   0, 0, 0);
		add_row(KIND_INSERT, 'h555,  0,   0, 0,   0,    0,   0, 0, 0);
		repeat (SLOTS - 1)
			add_row(KIND_REMOVE, 'hfff, 255, 0, 0, 0, 0, 0, 0, 0);
		add_row(KIND_REMOVE, 0,      0,   1, 0,   0,    0,   0, 0, 1);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		remove_pct = 50;
		for (n = 0; n < RANDOM_OPS; n++) begin
			// drift between filling, draining and balanced traffic
			if (n % 40 == 0) begin
				case ($urandom_range(0, 3))
					0: remove_pct = 5;
					1: remove_pct = 85;
					2: remove_pct = 30;
					default: remove_pct = 50;
				endcase
			end
			steady = (n >= 500 && n < 700);
			if (n == 300)
				pressure_go = 1'b1;
			height_pick = $urandom_range(0, 9);
			row.op_kind = ($urandom_range(0, 99) < remove_pct) ? KIND_REMOVE : KIND_INSERT;
			row.op_key  = KEY_W'($urandom_range(0, 4095));
			case (height_pick)
				0: row.op_height = '0;
				1: row.op_height = '1;
				2, 3: row.op_height = HEIGHT_W'($urandom_range(0, 3));
				default: row.op_height = HEIGHT_W'($urandom_range(0, 255));
			endcase
			row.pinned        = 1'b0;
			row.pinned_result = '0;
			send_item(row);
		end
		item_valid <= 1'b0;
		steady = 1'b0;

		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && outcomes_due.size() == 0)
			$display("** overwriting_queue_with_mean_unit: PASSED **");
		else
			$display("** overwriting_queue_with_mean_unit: FAILED **");
		$finish;
	end

	initial begin : receiver
		int   hold_left;
		logic hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
			end else if (pressure_go && !hold_used) begin
				// long hold-off so the unit backs up and stalls its input
				hold_left = HOLD_CYCLES;
				hold_used = 1'b1;
			end
			result_stall <= (hold_left > 0) ||
				(!steady && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	initial begin : result_checker
		queue_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				if (outcomes_due.size() == 0) begin
					report_mismatch("result with nothing pending, occupancy",
						32'(occupancy), 0);
				end else begin
					want = outcomes_due.pop_front();
					if (mean_height !== want.mean_height)
						report_mismatch("mean_height", 32'(mean_height),
							32'(want.mean_height));
					if (removed_key !== want.removed_key)
						report_mismatch("removed_key", 32'(removed_key),
							32'(want.removed_key));
					if (removed_height !== want.removed_height)
						report_mismatch("removed_height", 32'(removed_height),
							32'(want.removed_height));
					if (occupancy !== want.occupancy)
						report_mismatch("occupancy", 32'(occupancy),
							32'(want.occupancy));
					if (dropped_oldest !== want.dropped_oldest)
						report_mismatch("dropped_oldest", 32'(dropped_oldest),
							32'(want.dropped_oldest));
					if (underflow !== want.underflow)
						report_mismatch("underflow", 32'(underflow),
							32'(want.underflow));
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("** overwriting_queue_with_mean_unit: FAILED **");
		$finish;
	end

endmodule
